>>> rtl/sai_pkg.sv
package sai_pkg;

	localparam int MODE_W   = 3;
	localparam int POS_W    = 5;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	localparam int DEPTH_DEF = 16;
	localparam int WIDTH_DEF = 32;

	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_ERASE      = 3'd5;
	localparam logic [MODE_W-1:0] MODE_READ       = 3'd6;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0]       mode;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic [COUNT_W-1:0]      count;
		logic signed [VAL_W-1:0] read_value;
	} res_t;

	typedef enum logic [1:0] {
		DP_NONE   = 2'd0,
		DP_INSERT = 2'd1,
		DP_REMOVE = 2'd2,
		DP_READ   = 2'd3
	} dp_op_t;

	typedef struct packed {
		logic   en;
		dp_op_t op;
	} dp_ctl_t;

endpackage

>>> rtl/sai_datapath.sv
module sai_datapath #(
	parameter int DEPTH = sai_pkg::DEPTH_DEF,
	parameter int WIDTH = sai_pkg::WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sai_pkg::dp_ctl_t                    ctl,
	input  logic [$clog2(DEPTH)-1:0]            pos,
	input  logic signed [sai_pkg::VAL_W-1:0]    value,
	output logic signed [sai_pkg::VAL_W-1:0]    read_value
);
	import sai_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);

	logic [WIDTH-1:0] cells_q [DEPTH];
	logic [WIDTH-1:0] cells_d [DEPTH];
	logic [WIDTH-1:0] store_val;
	logic [WIDTH-1:0] rd_cell;
	logic [VAL_W-1:0] rd_ext;
	logic [VAL_W-1:0] read_value_q;

	// incoming word is sign extended or cut to the cell width
	if (WIDTH <= VAL_W) begin : g_store_narrow
		assign store_val = value[WIDTH-1:0];
	end else begin : g_store_wide
		assign store_val = {{(WIDTH-VAL_W){value[VAL_W-1]}}, value};
	end

	assign rd_cell = cells_q[pos];

	if (WIDTH >= VAL_W) begin : g_rd_wide
		assign rd_ext = rd_cell[VAL_W-1:0];
	end else begin : g_rd_narrow
		assign rd_ext = {{(VAL_W-WIDTH){rd_cell[WIDTH-1]}}, rd_cell};
	end

	// each cell picks from itself, its lower or upper neighbor, or the new word
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic above;
		logic at_pos;
		logic [WIDTH-1:0] lower;
		logic [WIDTH-1:0] upper;

		assign above  = IDX_W'(g) > pos;
		assign at_pos = IDX_W'(g) == pos;

		if (g == 0) begin : g_first
			assign lower = '0;
		end else begin : g_mid
			assign lower = cells_q[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign upper = '0;
		end else begin : g_inner
			assign upper = cells_q[g+1];
		end

		always_comb begin
			cells_d[g] = cells_q[g];
			case (ctl.op)
				DP_INSERT: begin
					if (at_pos) begin
						cells_d[g] = store_val;
					end else if (above) begin
						cells_d[g] = lower;
					end
				end
				DP_REMOVE: begin
					if (at_pos || above) begin
						cells_d[g] = upper;
					end
				end
				default: begin
					cells_d[g] = cells_q[g];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				cells_q[i] <= '0;
			end
		end else if (ctl.en) begin
			for (int i = 0; i < DEPTH; i++) begin
				cells_q[i] <= cells_d[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			read_value_q <= (ctl.op == DP_READ) ? rd_ext : '0;
		end
	end

	assign read_value = read_value_q;

endmodule

>>> rtl/sai_ctrl.sv
module sai_ctrl #(
	parameter int DEPTH = sai_pkg::DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_stall,
	input  sai_pkg::cmd_t                   cmd,
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic [sai_pkg::STATUS_W-1:0]    status,
	output logic [sai_pkg::COUNT_W-1:0]     count,
	output sai_pkg::dp_ctl_t                dp_ctl,
	output logic [$clog2(DEPTH)-1:0]        dp_pos
);
	import sai_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_HOLD = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    cnt_d;
	logic [STATUS_W-1:0] status_d;
	logic [STATUS_W-1:0] status_q;
	logic [COUNT_W-1:0]  count_q;
	logic [CMP_W-1:0]    pos_ext;
	logic [CMP_W-1:0]    cnt_ext;
	logic                full;
	logic                empty;
	logic                accept;
	dp_op_t              op;

	assign res_valid = (state_q == ST_HOLD);
	assign cmd_stall = res_valid && res_stall;
	assign accept    = cmd_valid && !cmd_stall;

	assign pos_ext = CMP_W'(cmd.position);
	assign cnt_ext = CMP_W'(cnt_q);
	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);

	always_comb begin
		op       = DP_NONE;
		status_d = STATUS_OK;
		cnt_d    = cnt_q;
		dp_pos   = '0;
		case (cmd.mode)
			MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INSERT: begin
				if (full) begin
					status_d = STATUS_FULL;
				end else if (cmd.mode == MODE_INSERT && pos_ext > cnt_ext) begin
					status_d = STATUS_RANGE;
				end else begin
					op    = DP_INSERT;
					cnt_d = cnt_q + 1'b1;
					if (cmd.mode == MODE_PUSH_BACK) begin
						dp_pos = IDX_W'(cnt_q);
					end else if (cmd.mode == MODE_INSERT) begin
						dp_pos = IDX_W'(pos_ext);
					end
				end
			end
			MODE_POP_FRONT, MODE_POP_BACK, MODE_ERASE: begin
				if (empty) begin
					status_d = STATUS_EMPTY;
				end else if (cmd.mode == MODE_ERASE && pos_ext >= cnt_ext) begin
					status_d = STATUS_RANGE;
				end else begin
					op    = DP_REMOVE;
					cnt_d = cnt_q - 1'b1;
					if (cmd.mode == MODE_POP_BACK) begin
						dp_pos = IDX_W'(cnt_q - 1'b1);
					end else if (cmd.mode == MODE_ERASE) begin
						dp_pos = IDX_W'(pos_ext);
					end
				end
			end
			MODE_READ: begin
				// out of range also covers the empty list
				if (pos_ext >= cnt_ext) begin
					status_d = STATUS_RANGE;
				end else begin
					op     = DP_READ;
					dp_pos = IDX_W'(pos_ext);
				end
			end
			default: begin
				op = DP_NONE;
			end
		endcase
	end

	assign dp_ctl.en = accept;
	assign dp_ctl.op = op;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				// a new transfer may come in the same cycle the result leaves
				if (!res_stall && !accept) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= cnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			count_q  <= COUNT_W'(cnt_d);
		end
	end

	assign status = status_q;
	assign count  = count_q;

endmodule

>>> rtl/shift_array_insert_erase_top.sv
// Ordered list of up to DEPTH signed words held in a chain of cells that all
// shift on the same edge: push and pop at either end, insert, erase and read
// at a position. Every command transfer yields exactly one result with a
// status (ok, full, empty, position out of range), the fill count after the
// command and, for a good read, the word read. The controller checks each
// command against the fill count and the cell chain updates at the edge that
// takes it, with the result held in an output register. A new command can be
// taken while the last result is held; cmd_stall rises only while a result
// waits on res_stall. Failed commands leave the list unchanged.
module shift_array_insert_erase_top #(
	parameter int DEPTH = sai_pkg::DEPTH_DEF,
	parameter int WIDTH = sai_pkg::WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  sai_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output sai_pkg::res_t res
);
	import sai_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);

	dp_ctl_t                 dp_ctl;
	logic [IDX_W-1:0]        dp_pos;
	logic [STATUS_W-1:0]     status;
	logic [COUNT_W-1:0]      count;
	logic signed [VAL_W-1:0] read_value;

	sai_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.status    (status),
		.count     (count),
		.dp_ctl    (dp_ctl),
		.dp_pos    (dp_pos)
	);

	sai_datapath #(
		.DEPTH(DEPTH),
		.WIDTH(WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (dp_ctl),
		.pos        (dp_pos),
		.value      (cmd.value),
		.read_value (read_value)
	);

	always_comb begin
		res.status     = status;
		res.count      = count;
		res.read_value = read_value;
	end

endmodule

>>> rtl/sai_checker.sv
module sai_checker #(
	parameter int DEPTH = sai_pkg::DEPTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_stall,
	input logic          res_valid,
	input logic          res_stall,
	input sai_pkg::res_t res
);
	import sai_pkg::*;

	// a held result stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// commands are only held back by a waiting result
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !cmd_stall)
		else $error("command stalled with no result pending");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == STATUS_FULL |-> res.count == COUNT_W'(DEPTH))
		else $error("full status with short count");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == STATUS_EMPTY |-> res.count == '0)
		else $error("empty status with nonzero count");

	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.read_value != '0 |-> res.status == STATUS_OK)
		else $error("read data on a failed command");

endmodule

bind shift_array_insert_erase_top sai_checker #(
	.DEPTH(DEPTH)
) u_sai_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_stall (cmd_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
